/* hw/rtl/ramit_pkg.sv */
// Shared constants, codes and helper functions of the random affine map iterator.
// No dependencies; the iterator refers to this package by scoped names.
package ramit_pkg;

	localparam int NUM_COLS      = 11;
	localparam int DEF_MAX_MAPS  = 16;
	localparam int DEF_FRAC_BITS = 16;
	localparam int APB_AW        = 4;

	// Item commands
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_STEP    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_MAP_COUNT = 2'd0;
	localparam logic [1:0] REG_START_X1  = 2'd1;
	localparam logic [1:0] REG_START_X2  = 2'd2;

	// Table columns used by the range rules
	localparam logic [3:0] COL_PROB     = 4'd0;
	localparam logic [3:0] COL_LAST_LIN = 4'd6;

	// Range check of one table word; one is 1.0 in the table's fixed point.
	function automatic logic word_bad(input logic [3:0] col, input logic signed [31:0] v,
			input logic signed [31:0] one);
		logic bad;
		if (v < 0) begin
			bad = 1'b1;
		end else if (col == COL_PROB) begin
			bad = (v > one);
		end else if (col <= COL_LAST_LIN) begin
			bad = (v >= one);
		end else begin
			bad = 1'b0;
		end
		return bad;
	endfunction

	// Clamp a wide signed result to 32 bits signed.
	function automatic logic [31:0] sat32(input logic signed [65:0] y);
		logic [31:0] r;
		if (y > 66'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (y < -66'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = y[31:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/ramit_if.sv */
// Valid/ready channel interfaces for the command items and the result items.
// Depends on nothing; field widths are fixed by the item formats.
interface ramit_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [3:0]         row;
	logic [3:0]         column;
	logic signed [31:0] word_value;
	logic [16:0]        random_draw;

	modport source (output valid, command, row, column, word_value, random_draw,
		input ready);
	modport sink (input valid, command, row, column, word_value, random_draw,
		output ready);
endinterface

interface ramit_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x1;
	logic signed [31:0] x2;
	logic [3:0]         chosen_map;
	logic               params_valid;

	modport source (output valid, x1, x2, chosen_map, params_valid, input ready);
	modport sink (input valid, x1, x2, chosen_map, params_valid, output ready);
endinterface

/* hw/rtl/random_affine_map_iterator.sv */
// Random affine map iterator (2-D chaos game) in Q(31-FRAC_BITS).FRAC_BITS fixed point.
// Uses ramit_pkg, ramit_req_if / ramit_rsp_if and ramit_ram.
//
// Items arrive on req (valid/ready). command 0 writes one table word (row, column,
// word_value) and range-checks it, 1 takes a step with random_draw, 2 reloads the
// state from start_x1/start_x2. Every item yields exactly one result on rsp: the
// state x1/x2 after the item, the row of the last step and the validity flag.
// Registers map_count, start_x1, start_x2 sit on the APB port at 0x0, 0x4, 0x8.
//
// Each item walks the probability column of the first n - 1 rows in use through
// the table read port (one row per cycle), which yields both the validity sum and
// the row search. A step then reads ten words of the chosen row, forms A and b and
// runs four products through one shared 32x32 multiplier. req is ready only while
// no item is in progress; one finished result waits in the output register, so a
// new item is taken while rsp is stalled, and its result is held back until the
// previous one leaves. Reset clears the state and the bad marks, zeroes start_x1
// and start_x2 and sets map_count to 1; table words read as undefined until written.
module random_affine_map_iterator #(
	parameter int MAX_MAPS  = ramit_pkg::DEF_MAX_MAPS,
	parameter int FRAC_BITS = ramit_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ramit_req_if.sink                     req,
	ramit_rsp_if.source                   rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ramit_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int DEPTH = MAX_MAPS * ramit_pkg::NUM_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RCW   = $clog2(MAX_MAPS + 1);
	localparam int SW    = 32 + RCW + 1;
	localparam int ZW    = FRAC_BITS + 1;
	localparam logic signed [31:0] ONE_W = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< FRAC_BITS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_COEF  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;

	// configuration
	logic [4:0]         map_count_q;
	logic signed [31:0] start_x1_q;
	logic signed [31:0] start_x2_q;

	// architectural state
	logic signed [31:0] x1_q, x2_q;
	logic [3:0]         last_map_q;
	logic               valid_q;
	logic [10:0]        mask_q [MAX_MAPS];

	// item
	logic [1:0]    cmd_q;
	logic [ZW-1:0] z_q;

	// walk
	logic [RCW-1:0]       iss_cnt_q, acc_cnt_q, pick_q;
	logic [AW-1:0]        iss_addr_q, acc_addr_q, pick_addr_q;
	logic                 rdv_q, hit_q;
	logic signed [SW-1:0] sum_q;

	// fetch and arithmetic
	logic [3:0]         fc_q, frc_q;
	logic               frv_q;
	logic [31:0]        p_q [1:10];
	logic signed [31:0] a_q [4];
	logic signed [33:0] b1_q, b2_q;
	logic [2:0]         mc_q;
	logic signed [63:0] prod_s1;
	logic               pv_s1;
	logic [1:0]         pk_s1;
	logic signed [64:0] acc1_q, acc2_q;

	// output register
	logic               out_vq;
	logic signed [31:0] ox1_q, ox2_q;
	logic [3:0]         omap_q;
	logic               ovalid_q;

	// table port
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;

	logic                 accept, wr_ok, wr_bad, cfg_we, iss_re, fetch_re, bad_any;
	logic [RCW-1:0]       n_eff, nm1;
	logic [ZW+15:0]       zfull;
	logic signed [SW-1:0] sum_n, z_s;
	logic signed [65:0]   y1, y2;

	assign pready    = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && (state_q == S_IDLE);
	assign cfg_we    = psel && penable && pwrite;

	assign rsp.valid        = out_vq;
	assign rsp.x1           = ox1_q;
	assign rsp.x2           = ox2_q;
	assign rsp.chosen_map   = omap_q;
	assign rsp.params_valid = ovalid_q;

	always_comb begin
		case (paddr[3:2])
			ramit_pkg::REG_MAP_COUNT: prdata = {27'b0, map_count_q};
			ramit_pkg::REG_START_X1:  prdata = start_x1_q;
			ramit_pkg::REG_START_X2:  prdata = start_x2_q;
			default:                  prdata = 32'b0;
		endcase
	end

	// effective map count: zero counts as one, clamp to the table size
	always_comb begin
		if (map_count_q == 5'd0) begin
			n_eff = RCW'(1);
		end else if (32'(map_count_q) > MAX_MAPS) begin
			n_eff = RCW'(MAX_MAPS);
		end else begin
			n_eff = RCW'(map_count_q);
		end
	end
	assign nm1 = n_eff - RCW'(1);

	// bad marks of rows in use; the last row's probability is implied
	always_comb begin
		logic [10:0] m;
		bad_any = 1'b0;
		for (int r = 0; r < MAX_MAPS; r++) begin
			m = mask_q[r];
			if (RCW'(r) == nm1) begin
				m[0] = 1'b0;
			end
			if ((RCW'(r) < n_eff) && (m != 11'b0)) begin
				bad_any = 1'b1;
			end
		end
	end

	assign wr_ok = (req.command == ramit_pkg::CMD_WRITE) && (32'(req.row) < MAX_MAPS)
		&& (32'(req.column) < ramit_pkg::NUM_COLS);
	assign wr_bad = ramit_pkg::word_bad(req.column, req.word_value, ONE_W);
	assign ram_we = accept && wr_ok;
	assign ram_waddr = AW'(32'(req.row) * ramit_pkg::NUM_COLS + 32'(req.column));
	assign zfull = {req.random_draw, {FRAC_BITS{1'b0}}};

	assign iss_re   = (state_q == S_WALK) && (iss_cnt_q < nm1);
	assign fetch_re = (state_q == S_FETCH) && (fc_q <= 4'd10);
	assign ram_raddr = (state_q == S_FETCH) ? pick_addr_q + AW'(fc_q) : iss_addr_q;

	assign sum_n = sum_q + SW'($signed(ram_rdata));
	assign z_s   = $signed({{(SW-ZW){1'b0}}, z_q});

	assign y1 = 66'(acc1_q >>> FRAC_BITS) + 66'(b1_q);
	assign y2 = 66'(acc2_q >>> FRAC_BITS) + 66'(b2_q);

	ramit_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.word_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_count_q <= 5'd1;
			start_x1_q  <= '0;
			start_x2_q  <= '0;
		end else if (cfg_we) begin
			case (paddr[3:2])
				ramit_pkg::REG_MAP_COUNT: map_count_q <= pwdata[4:0];
				ramit_pkg::REG_START_X1:  start_x1_q  <= pwdata;
				ramit_pkg::REG_START_X2:  start_x2_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// per-row bad marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_MAPS; r++) begin
				mask_q[r] <= '0;
			end
		end else if (ram_we) begin
			for (int r = 0; r < MAX_MAPS; r++) begin
				for (int b = 0; b < ramit_pkg::NUM_COLS; b++) begin
					if ((32'(req.row) == r) && (32'(req.column) == b)) begin
						mask_q[r][b] <= wr_bad;
					end
				end
			end
		end
	end

	// shared multiplier: a11*x1, a12*x2, a21*x1, a22*x2
	always_ff @(posedge clk) begin
		prod_s1 <= a_q[mc_q[1:0]] * (mc_q[0] ? x2_q : x1_q);
		pk_s1   <= mc_q[1:0];
	end

	// table words of the chosen row
	always_ff @(posedge clk) begin
		if (frv_q) begin
			p_q[frc_q] <= ram_rdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x1_q        <= '0;
			x2_q        <= '0;
			last_map_q  <= '0;
			valid_q     <= 1'b1;
			cmd_q       <= '0;
			z_q         <= '0;
			iss_cnt_q   <= '0;
			acc_cnt_q   <= '0;
			pick_q      <= '0;
			iss_addr_q  <= '0;
			acc_addr_q  <= '0;
			pick_addr_q <= '0;
			rdv_q       <= 1'b0;
			hit_q       <= 1'b0;
			sum_q       <= '0;
			fc_q        <= '0;
			frc_q       <= '0;
			frv_q       <= 1'b0;
			mc_q        <= '0;
			pv_s1       <= 1'b0;
			acc1_q      <= '0;
			acc2_q      <= '0;
			for (int k = 0; k < 4; k++) begin
				a_q[k] <= '0;
			end
			b1_q        <= '0;
			b2_q        <= '0;
			out_vq      <= 1'b0;
			ox1_q       <= '0;
			ox2_q       <= '0;
			omap_q      <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_vq <= 1'b0;
			end
			pv_s1 <= (state_q == S_MUL) && (mc_q < 3'd4);
			if (pv_s1) begin
				if (pk_s1[1]) begin
					acc2_q <= acc2_q + 65'(prod_s1);
				end else begin
					acc1_q <= acc1_q + 65'(prod_s1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q      <= req.command;
						z_q        <= zfull[ZW+15:16];
						iss_cnt_q  <= '0;
						acc_cnt_q  <= '0;
						iss_addr_q <= '0;
						acc_addr_q <= '0;
						rdv_q      <= 1'b0;
						hit_q      <= 1'b0;
						sum_q      <= '0;
						if (req.command == ramit_pkg::CMD_RESTART) begin
							x1_q <= start_x1_q;
							x2_q <= start_x2_q;
						end
						state_q <= S_WALK;
					end
				end

				S_WALK: begin
					rdv_q <= iss_re;
					if (iss_re) begin
						iss_cnt_q  <= iss_cnt_q + RCW'(1);
						iss_addr_q <= iss_addr_q + AW'(ramit_pkg::NUM_COLS);
					end
					if (rdv_q) begin
						sum_q      <= sum_n;
						acc_cnt_q  <= acc_cnt_q + RCW'(1);
						acc_addr_q <= acc_addr_q + AW'(ramit_pkg::NUM_COLS);
						if (!hit_q && (z_s <= sum_n)) begin
							hit_q       <= 1'b1;
							pick_q      <= acc_cnt_q;
							pick_addr_q <= acc_addr_q;
						end
					end
					if (acc_cnt_q == nm1) begin
						valid_q <= !bad_any && (sum_q <= ONE_S);
						// no hit: the last row in use takes the remainder
						if (!hit_q) begin
							pick_q      <= acc_cnt_q;
							pick_addr_q <= acc_addr_q;
						end
						if (cmd_q == ramit_pkg::CMD_STEP) begin
							if (!bad_any && (sum_q <= ONE_S)) begin
								fc_q    <= 4'd1;
								frv_q   <= 1'b0;
								state_q <= S_FETCH;
							end else begin
								x1_q    <= '0;
								x2_q    <= '0;
								state_q <= S_DONE;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end

				S_FETCH: begin
					frv_q <= fetch_re;
					frc_q <= fc_q;
					if (fetch_re) begin
						fc_q <= fc_q + 4'd1;
					end
					if (frv_q && (frc_q == 4'd10)) begin
						state_q <= S_COEF;
					end
				end

				S_COEF: begin
					// columns: 1 m1, 2 m2, 3 c1, 4 c2, 5 i1, 6 i2, 7 m01, 8 m02, 9 i01, 10 i02
					a_q[0] <= 32'(34'($signed(p_q[3])) + 34'($signed(p_q[5]))
						- 34'($signed(p_q[1])));
					a_q[1] <= $signed(p_q[2]);
					a_q[2] <= $signed(p_q[1]);
					a_q[3] <= 32'(34'($signed(p_q[4])) + 34'($signed(p_q[6]))
						- 34'($signed(p_q[2])));
					b1_q <= 34'($signed(p_q[9])) + 34'($signed(p_q[8])) - 34'($signed(p_q[7]));
					b2_q <= 34'($signed(p_q[10])) + 34'($signed(p_q[7])) - 34'($signed(p_q[8]));
					acc1_q  <= '0;
					acc2_q  <= '0;
					mc_q    <= '0;
					state_q <= S_MUL;
				end

				S_MUL: begin
					// last product is folded in on the edge that leaves this state
					if (mc_q == 3'd4) begin
						state_q <= S_FIN;
					end else begin
						mc_q <= mc_q + 3'd1;
					end
				end

				S_FIN: begin
					x1_q       <= ramit_pkg::sat32(y1);
					x2_q       <= ramit_pkg::sat32(y2);
					last_map_q <= 4'(32'(pick_q));
					state_q    <= S_DONE;
				end

				S_DONE: begin
					// hold until the output register is free
					if (!out_vq || rsp.ready) begin
						out_vq   <= 1'b1;
						ox1_q    <= x1_q;
						ox2_q    <= x2_q;
						omap_q   <= last_map_q;
						ovalid_q <= valid_q;
						state_q  <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/ramit_ram.sv */
// Single-port-write, single-port-read parameter table with registered read data.
// Depends on nothing; depth and address width come from the top level.
module ramit_ram #(
	parameter int DEPTH = 176,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
